FILE: src/gn23_pkg.sv
// Package with the types, codes and arithmetic helpers of the gradient noise unit.
`timescale 1ns / 1ps
`default_nettype none
package gn23_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned FracW      = 16;
  localparam int unsigned GradW      = 16;
  localparam int unsigned ValW       = 22;
  localparam int unsigned OutW       = 19;
  localparam int unsigned InDataW    = 136;
  localparam int unsigned OutDataW   = 24;

  localparam logic signed [ValW-1:0] OutMax = 22'sd262143;
  localparam logic signed [ValW-1:0] OutMin = -22'sd262144;

  typedef enum logic [1:0] {
    KIND_PERM = 2'd0,
    KIND_GRAD = 2'd1,
    KIND_EVAL = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_DIMS = 2'd0,
    REG_SIZE = 2'd1
  } reg_index_t;

  typedef logic signed [ValW-1:0] val_t;

  function automatic logic [IdxW-1:0] index_mask(input logic [3:0] size_log2);
    logic [15:0] full;
    full = (16'd1 << size_log2) - 16'd1;
    return full[IdxW-1:0];
  endfunction

  function automatic val_t lerp(input val_t a, input val_t b, input logic [16:0] s);
    logic signed [ValW:0]    diff;
    logic signed [ValW+18:0] prod;
    logic signed [ValW+18:0] step;
    diff = $signed({b[ValW-1], b}) - $signed({a[ValW-1], a});
    prod = diff * $signed({1'b0, s});
    step = prod >>> FracW;
    return a + step[ValW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/gradient_noise_2d_3d_unit.sv
// Top level of the fixed-point 2-D and 3-D gradient noise unit.
// An evaluate transfer shows its result in the output register after it has passed every stage.
// Throughput: one transfer per cycle; the whole pipeline halts only while the
// output register holds a result that is not taken.
// Table loads write each table copy as they pass the stage that reads it.
// Reset clears the valid bits and sets dims to 3 and size_log2 to 8; the
// tables are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module gradient_noise_2d_3d_unit
  import gn23_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  // entry_index, grad_axis, perm_value, grad_value, x, y, z, zero padding
  input  wire [InDataW-1:0]   s_tdata,
  // kind
  input  wire [1:0]           s_tuser,
  output logic                m_tvalid,
  input  wire                 m_tready,
  // noise_value, zero padding
  output logic [OutDataW-1:0] m_tdata,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [1:0]           cfg_index,
  input  wire [3:0]           cfg_data
);

  logic [1:0] dims;
  logic [3:0] size_log2;
  logic [IdxW-1:0] mask;
  logic three_d;
  logic en;
  logic accept;

  logic [IdxW-1:0]  in_idx;
  logic [1:0]       in_axis;
  logic [7:0]       in_perm;
  logic [GradW-1:0] in_grad;
  logic [31:0]      in_x, in_y, in_z;

  assign in_idx  = s_tdata[7:0];
  assign in_axis = s_tdata[9:8];
  assign in_perm = s_tdata[17:10];
  assign in_grad = s_tdata[33:18];
  assign in_x    = s_tdata[65:34];
  assign in_y    = s_tdata[97:66];
  assign in_z    = s_tdata[129:98];

  assign mask      = index_mask(size_log2);
  assign three_d   = (dims != 2'd2);
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign accept    = s_tvalid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims      <= 2'd3;
      size_log2 <= 4'd8;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_DIMS: dims      <= cfg_data[1:0];
        REG_SIZE: size_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: lattice indices, fractions, squares and first permutation lookup.
  logic [7:0] perm_a [TableDepth];
  logic             v1;
  kind_t            k1;
  logic [IdxW-1:0]  idx1;
  logic [1:0]       axis1;
  logic [7:0]       pv1;
  logic [GradW-1:0] gv1;
  logic [IdxW-1:0]  yi0_1, yi1_1, zi0_1, zi1_1;
  logic [FracW-1:0] xr1, yr1, zr1, xq1, yq1, zq1;
  logic [7:0]       p0, p1;
  logic [31:0]      xsq, ysq, zsq;

  assign xsq = in_x[15:0] * in_x[15:0];
  assign ysq = in_y[15:0] * in_y[15:0];
  assign zsq = in_z[15:0] * in_z[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (accept && kind_t'(s_tuser) == KIND_PERM) begin
        perm_a[in_idx] <= in_perm;
      end
      p0    <= perm_a[in_x[23:16] & mask];
      p1    <= perm_a[(in_x[23:16] + 8'd1) & mask];
      k1    <= kind_t'(s_tuser);
      idx1  <= in_idx;
      axis1 <= in_axis;
      pv1   <= in_perm;
      gv1   <= in_grad;
      yi0_1 <= in_y[23:16] & mask;
      yi1_1 <= (in_y[23:16] + 8'd1) & mask;
      zi0_1 <= in_z[23:16] & mask;
      zi1_1 <= (in_z[23:16] + 8'd1) & mask;
      xr1   <= in_x[15:0];
      yr1   <= in_y[15:0];
      zr1   <= in_z[15:0];
      xq1   <= xsq[31:16];
      yq1   <= ysq[31:16];
      zq1   <= zsq[31:16];
    end
  end

  // Stage 2: second permutation lookup and smoothstep weights.
  logic [7:0] perm_b [TableDepth];
  logic [7:0] perm_c [TableDepth];
  logic             v2;
  kind_t            k2;
  logic [IdxW-1:0]  idx2;
  logic [1:0]       axis2;
  logic [GradW-1:0] gv2;
  logic [IdxW-1:0]  zi0_2, zi1_2;
  logic [FracW-1:0] xr2, yr2, zr2;
  logic [16:0]      xs2, ys2, zs2;
  logic [7:0]       c00, c10, c01, c11;
  logic [33:0]      xsm, ysm, zsm;

  assign xsm = xq1 * (18'd196608 - {1'b0, xr1, 1'b0});
  assign ysm = yq1 * (18'd196608 - {1'b0, yr1, 1'b0});
  assign zsm = zq1 * (18'd196608 - {1'b0, zr1, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v1 && k1 == KIND_PERM) begin
        perm_b[idx1] <= pv1;
        perm_c[idx1] <= pv1;
      end
      c00   <= perm_b[(p0 + yi0_1) & mask];
      c10   <= perm_b[(p1 + yi0_1) & mask];
      c01   <= perm_c[(p0 + yi1_1) & mask];
      c11   <= perm_c[(p1 + yi1_1) & mask];
      k2    <= k1;
      idx2  <= idx1;
      axis2 <= axis1;
      gv2   <= gv1;
      zi0_2 <= zi0_1;
      zi1_2 <= zi1_1;
      xr2   <= xr1;
      yr2   <= yr1;
      zr2   <= zr1;
      xs2   <= xsm[32:16];
      ys2   <= ysm[32:16];
      zs2   <= zsm[32:16];
    end
  end

  // Stage 3: gradient lookups for the eight corners, two per table copy.
  logic [GradW-1:0] grad_xm [4][TableDepth];
  logic [GradW-1:0] grad_ym [4][TableDepth];
  logic [GradW-1:0] grad_zm [4][TableDepth];
  logic [IdxW-1:0]  corner_idx [8];
  logic [GradW-1:0] gx3 [8];
  logic [GradW-1:0] gy3 [8];
  logic [GradW-1:0] gz3 [8];
  logic             v3;
  logic [FracW-1:0] xr3, yr3, zr3;
  logic [16:0]      xs3, ys3, zs3;
  logic             wr_x, wr_y, wr_z;

  assign wr_x = v2 && k2 == KIND_GRAD && axis2 == 2'd0;
  assign wr_y = v2 && k2 == KIND_GRAD && axis2 == 2'd1;
  assign wr_z = v2 && k2 == KIND_GRAD && axis2 == 2'd2;

  always_comb begin
    logic [7:0] cxy;
    logic [7:0] zo;
    for (int n = 0; n < 8; n++) begin
      case (n[1:0])
        2'd0:    cxy = c00;
        2'd1:    cxy = c10;
        2'd2:    cxy = c01;
        default: cxy = c11;
      endcase
      zo = n[2] ? zi1_2 : zi0_2;
      corner_idx[n] = three_d ? ((cxy + zo) & mask) : cxy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2 && k2 == KIND_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 4; m++) begin
        if (wr_x) grad_xm[m][idx2] <= gv2;
        if (wr_y) grad_ym[m][idx2] <= gv2;
        if (wr_z) grad_zm[m][idx2] <= gv2;
        gx3[2*m]   <= grad_xm[m][corner_idx[2*m]];
        gx3[2*m+1] <= grad_xm[m][corner_idx[2*m+1]];
        gy3[2*m]   <= grad_ym[m][corner_idx[2*m]];
        gy3[2*m+1] <= grad_ym[m][corner_idx[2*m+1]];
        gz3[2*m]   <= grad_zm[m][corner_idx[2*m]];
        gz3[2*m+1] <= grad_zm[m][corner_idx[2*m+1]];
      end
      xr3 <= xr2;
      yr3 <= yr2;
      zr3 <= zr2;
      xs3 <= xs2;
      ys3 <= ys2;
      zs3 <= zs2;
    end
  end

  // Stage 4: offset times gradient products.
  logic signed [32:0] px4 [8];
  logic signed [32:0] py4 [8];
  logic signed [32:0] pz4 [8];
  logic               v4;
  logic [16:0]        xs4, ys4, zs4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 8; n++) begin
        px4[n] <= $signed({n[0], xr3}) * $signed(gx3[n]);
        py4[n] <= $signed({n[1], yr3}) * $signed(gy3[n]);
        pz4[n] <= three_d ? $signed({n[2], zr3}) * $signed(gz3[n]) : 33'sd0;
      end
      xs4 <= xs3;
      ys4 <= ys3;
      zs4 <= zs3;
    end
  end

  // Stage 5: corner dot products.
  val_t        corner5 [8];
  logic        v5;
  logic [16:0] xs5, ys5, zs5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [34:0] sum;
    logic signed [34:0] shifted;
    if (en) begin
      for (int n = 0; n < 8; n++) begin
        sum = 35'(px4[n]) + 35'(py4[n]) + 35'(pz4[n]);
        shifted = sum >>> 14;
        corner5[n] <= shifted[ValW-1:0];
      end
      xs5 <= xs4;
      ys5 <= ys4;
      zs5 <= zs4;
    end
  end

  // Stage 6: blend along x.
  val_t        ab6 [4];
  logic        v6;
  logic [16:0] ys6, zs6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 4; m++) begin
        ab6[m] <= lerp(corner5[2*m], corner5[2*m+1], xs5);
      end
      ys6 <= ys5;
      zs6 <= zs5;
    end
  end

  // Stage 7: blend along y.
  val_t        cd7 [2];
  logic        v7;
  logic [16:0] zs7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd7[0] <= lerp(ab6[0], ab6[1], ys6);
      cd7[1] <= lerp(ab6[2], ab6[3], ys6);
      zs7    <= zs6;
    end
  end

  // Stage 8: blend along z when three-dimensional, saturate and present the result.
  val_t noise_full;
  val_t noise_sat;

  assign noise_full = three_d ? lerp(cd7[0], cd7[1], zs7) : cd7[0];

  always_comb begin
    if (noise_full > OutMax) begin
      noise_sat = OutMax;
    end else if (noise_full < OutMin) begin
      noise_sat = OutMin;
    end else begin
      noise_sat = noise_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {{(OutDataW-OutW){1'b0}}, noise_sat[OutW-1:0]};
    end
  end

endmodule
`default_nettype wire
